>>> src/rhh_pkg.sv
// Package for the Robin Hood hash table: request, response and configuration
// payload types, the slot word, operation and status codes, and control structs.
// No dependencies.
package rhh_pkg;

    // Fixed field widths.
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int HASH_W  = 32;
    localparam int CNT_W   = 7;
    localparam int PRB_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Probe counts with a special meaning.
    localparam logic [PRB_W-1:0] PROBES_EMPTY = 8'd0;
    localparam logic [PRB_W-1:0] PROBES_TOMB  = 8'd255;
    localparam logic [PRB_W-1:0] PROBES_CAP   = 8'd254;
    localparam logic [CNT_W-1:0] ENTRY_MAX    = 7'd127;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_LIMIT = 2'd1;
    localparam logic [CNT_W-1:0] LOAD_LIMIT_RST  = 7'd48;
    localparam logic [CNT_W-1:0] PROBE_LIMIT_RST = 7'd64;

    // Operation codes.
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_PRESENT   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_OVERFLOW  = 3'd6;

    typedef struct packed {
        logic [1:0]        mode;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] key_hash;
        logic [VAL_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [VAL_W-1:0] value_out;
        logic [CNT_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CNT_W-1:0]     data;
    } cfg_t;

    // One table slot as held in memory.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [HASH_W-1:0] hash;
        logic [PRB_W-1:0]  probes;
    } slot_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic probe;
        logic eval;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic early_done;
        logic overflow;
        logic eval_done;
        logic out_free;
    } stat_t;

endpackage

>>> src/rhh_chan_if.sv
// Valid/ready channel interface carrying one payload item.
// The payload type is set per instance from rhh_pkg.
interface rhh_chan_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/rhh_ctrl.sv
// Controller state machine for the Robin Hood hash table.
// Depends on rhh_pkg for the command and status structs.
module rhh_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  rhh_pkg::stat_t stat,
    output rhh_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROBE = 4'b0010,
        S_EVAL  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // The table takes a new item only between requests.
    assign req_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.early_done ? S_DONE : S_PROBE;
                end
            end
            S_PROBE:
            begin
                cmd.probe  = 1'b1;
                state_next = stat.overflow ? S_DONE : S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.eval_done ? S_DONE : S_PROBE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/rhh_dp.sv
// Datapath for the Robin Hood hash table: slot memory, entry in hand, probe
// counters, configuration registers, entry count and the response register.
// Depends on rhh_pkg and rhh_chan_if.
module rhh_dp #(
    parameter int SLOTS = 64
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  rhh_pkg::req_t  req,
    rhh_chan_if.sink       cfg,
    rhh_chan_if.source     rsp,
    input  rhh_pkg::cmd_t  cmd,
    output rhh_pkg::stat_t stat
);

    localparam int IW = $clog2(SLOTS);

    // Slot memory and its valid bits.
    rhh_pkg::slot_t mem [SLOTS];
    logic [SLOTS-1:0] vld_reg;
    rhh_pkg::slot_t rd_reg;
    logic           rd_vld_reg;

    // Request in hand.
    logic [1:0]                  mode_reg;
    logic [rhh_pkg::KEY_W-1:0]   key_reg;
    logic [rhh_pkg::VAL_W-1:0]   val_reg;
    logic [rhh_pkg::HASH_W-1:0]  hash_reg;
    logic [rhh_pkg::PRB_W-1:0]   n_reg;
    logic [rhh_pkg::PRB_W-1:0]   visits_reg;
    logic                        tomb_reg;
    logic [IW-1:0]               tomb_idx_reg;
    logic [rhh_pkg::PRB_W-1:0]   tomb_n_reg;
    logic [IW-1:0]               idx_reg;

    // Result and counters.
    logic [2:0]                  res_status_reg;
    logic [rhh_pkg::VAL_W-1:0]   res_value_reg;
    logic [rhh_pkg::CNT_W-1:0]   count_reg;
    logic [rhh_pkg::CNT_W-1:0]   load_limit_reg;
    logic [rhh_pkg::CNT_W-1:0]   probe_limit_reg;
    logic                        out_valid_reg;
    rhh_pkg::rsp_t               out_reg;

    // Probe position and decision signals.
    logic [15:0]              n_sq;
    logic [IW-1:0]            probe_idx;
    logic [rhh_pkg::PRB_W-1:0] p;
    logic                     is_empty;
    logic                     is_tomb;
    logic                     is_match;
    logic                     is_insert;
    logic                     full;
    logic                     we;
    logic [IW-1:0]            waddr;
    rhh_pkg::slot_t           wdata;

    assign n_sq      = 16'(n_reg) * 16'(n_reg);
    assign probe_idx = hash_reg[IW-1:0] + n_sq[IW-1:0];
    assign p         = rd_vld_reg ? rd_reg.probes : rhh_pkg::PROBES_EMPTY;
    assign is_empty  = (p == rhh_pkg::PROBES_EMPTY);
    assign is_tomb   = (p == rhh_pkg::PROBES_TOMB);
    assign is_match  = (rd_reg.hash == hash_reg) && (rd_reg.key == key_reg);
    assign is_insert = (mode_reg == rhh_pkg::MODE_INSERT);
    assign full      = (count_reg > load_limit_reg) || (count_reg >= rhh_pkg::ENTRY_MAX);

    // Status toward the controller.
    always_comb
    begin
        stat.early_done = ((req.mode == rhh_pkg::MODE_INSERT) && full)
                       || ((req.mode != rhh_pkg::MODE_INSERT)
                           && (req.mode != rhh_pkg::MODE_LOOKUP)
                           && (req.mode != rhh_pkg::MODE_REMOVE));
        stat.overflow   = (visits_reg >= rhh_pkg::PRB_W'(probe_limit_reg))
                       || (n_reg >= rhh_pkg::PROBES_CAP);
        // Every mode walks past tombstones and non-matching residents.
        stat.eval_done  = !is_tomb && (is_empty || is_match);
        stat.out_free   = !out_valid_reg || rsp.ready;
    end

    // Memory write selection for the evaluate step.
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = '{key: key_reg, value: val_reg, hash: hash_reg, probes: n_reg};
        if (cmd.eval && !is_tomb)
        begin
            if (is_insert)
            begin
                if (is_empty)
                begin
                    we = 1'b1;
                    if (tomb_reg)
                    begin
                        waddr        = tomb_idx_reg;
                        wdata.probes = tomb_n_reg;
                    end
                end
                else if (!is_match && (p < n_reg))
                begin
                    we = 1'b1;
                end
            end
            else if (!is_empty && is_match && (mode_reg == rhh_pkg::MODE_REMOVE))
            begin
                we           = 1'b1;
                wdata        = rd_reg;
                wdata.probes = rhh_pkg::PROBES_TOMB;
            end
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.probe)
        begin
            rd_reg <= mem[probe_idx];
        end
    end

    // Valid bits and the valid flag of the slot just read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (cmd.probe)
            begin
                rd_vld_reg <= vld_reg[probe_idx];
            end
        end
    end

    // Entry in hand and probe bookkeeping.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= req.mode;
            key_reg    <= req.key;
            val_reg    <= req.value;
            hash_reg   <= req.key_hash;
            n_reg      <= '0;
            visits_reg <= '0;
            tomb_reg   <= 1'b0;
        end
        else if (cmd.probe && !stat.overflow)
        begin
            idx_reg    <= probe_idx;
            n_reg      <= n_reg + 1'b1;
            visits_reg <= visits_reg + 1'b1;
        end
        else if (cmd.eval && is_insert)
        begin
            if (is_tomb)
            begin
                if (!tomb_reg)
                begin
                    tomb_reg     <= 1'b1;
                    tomb_idx_reg <= idx_reg;
                    tomb_n_reg   <= n_reg;
                end
            end
            else if (!is_empty && !is_match && (p < n_reg))
            begin
                // Displace the resident and carry it on.
                key_reg  <= rd_reg.key;
                val_reg  <= rd_reg.value;
                hash_reg <= rd_reg.hash;
                n_reg    <= p;
                tomb_reg <= 1'b0;
            end
        end
    end

    // Result of the request.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_value_reg  <= '0;
            res_status_reg <= (req.mode == rhh_pkg::MODE_INSERT) ? rhh_pkg::ST_FULL
                                                                  : rhh_pkg::ST_NOT_FOUND;
        end
        else if (cmd.probe && stat.overflow)
        begin
            res_status_reg <= rhh_pkg::ST_OVERFLOW;
        end
        else if (cmd.eval && !is_tomb)
        begin
            if (is_insert)
            begin
                res_status_reg <= is_empty ? rhh_pkg::ST_INSERTED : rhh_pkg::ST_PRESENT;
            end
            else if (is_empty || !is_match)
            begin
                res_status_reg <= rhh_pkg::ST_NOT_FOUND;
            end
            else
            begin
                res_value_reg  <= rd_reg.value;
                res_status_reg <= (mode_reg == rhh_pkg::MODE_REMOVE) ? rhh_pkg::ST_REMOVED
                                                                      : rhh_pkg::ST_FOUND;
            end
        end
    end

    // Entry count, configuration registers and the response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            load_limit_reg  <= rhh_pkg::LOAD_LIMIT_RST;
            probe_limit_reg <= rhh_pkg::PROBE_LIMIT_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.eval && !is_tomb)
            begin
                if (is_insert && is_empty)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else if (!is_insert && !is_empty && is_match
                         && (mode_reg == rhh_pkg::MODE_REMOVE) && (count_reg != '0))
                begin
                    count_reg <= count_reg - 1'b1;
                end
            end
            if (cfg.valid)
            begin
                if (cfg.payload.index == rhh_pkg::CFG_LOAD_LIMIT)
                begin
                    load_limit_reg <= cfg.payload.data;
                end
                else if (cfg.payload.index == rhh_pkg::CFG_PROBE_LIMIT)
                begin
                    probe_limit_reg <= cfg.payload.data;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg <= '{status: res_status_reg, value_out: res_value_reg,
                         entry_count: count_reg};
        end
    end

    assign cfg.ready   = 1'b1;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

endmodule

>>> src/robin_hood_hash_table.sv
// Robin Hood hash table, top level: controller plus datapath.
// Each accepted request is loaded, then each slot visited takes a probe and an evaluate step,
// and a done step emits the result; the probe limit ends it at a probe step, while full inserts
// and unknown modes go from load to done. One request at a time; the next follows its emit.
// Reset clears the valid bits and the entry count and loads the default limits; no clearing pass.
// Depends on rhh_pkg, rhh_chan_if, rhh_ctrl and rhh_dp; SLOTS must be a power of two.
module robin_hood_hash_table #(
    parameter int SLOTS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    rhh_chan_if.sink   req,
    rhh_chan_if.sink   cfg,
    rhh_chan_if.source rsp
);

    rhh_pkg::cmd_t  cmd;
    rhh_pkg::stat_t stat;
    logic           req_ready;

    assign req.ready = req_ready;

    // Sequencing.
    rhh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage and compute.
    rhh_dp #(.SLOTS(SLOTS)) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.payload),
        .cfg   (cfg),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

    // A request is loaded only when it is really taken from the channel.
    a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (req.valid && req_ready))
        else $error("request loaded without a handshake");

    // At most one command is active per cycle.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one command active");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!rsp.valid || rsp.ready))
        else $error("result overwritten before it was taken");

endmodule
